// ----- hdl/lap3_pkg.sv -----
// Shared types, constants and the Laplacian kernel for the 3x3 Laplacian filter.
// Used by the channel interfaces, the column cells, the line buffer and the top level.
`default_nettype none

package lap3_pkg;

  localparam int PixW  = 8;
  localparam int CfgW  = 11;
  localparam int AddrW = 3;
  localparam int DataW = 32;

  localparam logic [CfgW-1:0] FrameWidthRst  = 11'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 11'd480;

  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // Index 0 is the top row of the column, index 2 the bottom row.
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    pix_t newer;
    pix_t older;
  } line_pair_t;

  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } res_t;

  // Eight neighbors minus eight times the center, kept modulo 256.
  function automatic pix_t laplace(col_t l, col_t m, col_t r);
    pix_t nsum;
    nsum = l[0] + l[1] + l[2] + r[0] + r[1] + r[2] + m[0] + m[2];
    return nsum - {m[1][PixW-4:0], 3'b000};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lap3_if.sv -----
// Valid/ready channel interfaces for the pixel stream and the filtered result stream.
// Depends on lap3_pkg for the payload types.
`default_nettype none

interface lap3_in_if;
  logic          valid;
  logic          ready;
  logic          op;
  lap3_pkg::pix_t pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface lap3_out_if;
  logic          valid;
  logic          ready;
  lap3_pkg::pix_t pixel_out;
  logic          frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/laplacian_3x3_convolution_top.sv -----
// 3x3 Laplacian filter on a raster stream of 8-bit pixels, with APB frame-size registers.
// Depends on lap3_pkg, lap3_if, lap3_cell and lap3_line_buf.
//
// Accepts one beat per clock while the skid register is empty and returns the Laplacian
// (eight neighbors minus eight times the center, low 8 bits, zero outside the frame) of
// the pixel one row and one column behind. The window is a chain of two column cells fed
// by a two-row line buffer of MAX_WIDTH words, read one beat ahead so a new beat needs no
// wait. A result is registered in the output register, or in a skid register while the
// output stalls, so input flows for one more beat. After the last pixel send width + 1
// drain beats (op = 1); the final result carries frame_last and the next frame starts.
// Drain beats sent before all pixels are in are taken and dropped. Width and height
// of zero act as one, values above MAX_WIDTH or MAX_HEIGHT act as those maxima.
`default_nettype none

module laplacian_3x3_convolution_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lap3_pkg::AddrW-1:0]    paddr,
  input  wire logic [lap3_pkg::DataW-1:0]    pwdata,
  output      logic [lap3_pkg::DataW-1:0]    prdata,
  output      logic                          pready,
  lap3_in_if.sink                            pix_i,
  lap3_out_if.source                         res_o
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = $clog2(MAX_HEIGHT + 3);
  localparam int DimW0 = ($clog2(MAX_WIDTH + 2) > $clog2(MAX_HEIGHT + 4)) ?
                         $clog2(MAX_WIDTH + 2) : $clog2(MAX_HEIGHT + 4);
  localparam int CmpW  = ((DimW0 > lap3_pkg::CfgW) ? DimW0 : lap3_pkg::CfgW) + 1;

  localparam logic [CmpW-1:0] MaxW   = CmpW'(MAX_WIDTH);
  localparam logic [CmpW-1:0] MaxH   = CmpW'(MAX_HEIGHT);
  localparam logic [RowW-1:0] RowSat = RowW'(MAX_HEIGHT + 2);

  // Configuration registers
  logic [lap3_pkg::CfgW-1:0] frame_width_q;
  logic [lap3_pkg::CfgW-1:0] frame_height_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lap3_pkg::FrameWidthRst;
      frame_height_q <= lap3_pkg::FrameHeightRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lap3_pkg::RegFrameWidth:  frame_width_q  <= pwdata[lap3_pkg::CfgW-1:0];
        lap3_pkg::RegFrameHeight: frame_height_q <= pwdata[lap3_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lap3_pkg::RegFrameWidth:  prdata = lap3_pkg::DataW'(frame_width_q);
      lap3_pkg::RegFrameHeight: prdata = lap3_pkg::DataW'(frame_height_q);
      default:                  prdata = '0;
    endcase
  end

  logic [CmpW-1:0] fw_ext;
  logic [CmpW-1:0] fh_ext;
  logic [CmpW-1:0] w_eff;
  logic [CmpW-1:0] h_eff;

  assign fw_ext = CmpW'(frame_width_q);
  assign fh_ext = CmpW'(frame_height_q);
  assign w_eff  = (fw_ext == '0) ? CmpW'(1) : ((fw_ext > MaxW) ? MaxW : fw_ext);
  assign h_eff  = (fh_ext == '0) ? CmpW'(1) : ((fh_ext > MaxH) ? MaxH : fh_ext);

  // Position counters
  logic [ColW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic [CmpW-1:0] row_ext;
  logic [CmpW-1:0] col_ext;

  assign row_ext = CmpW'(in_row_q);
  assign col_ext = CmpW'(in_col_q);

  // Output register and skid
  lap3_pkg::res_t out_q, skid_q;
  logic           out_vld_q, skid_vld_q;
  logic           pop;

  logic in_fire;
  logic in_pixels;
  logic step;
  logic emit;
  logic last;
  logic restart;
  logic row_wrap;
  logic col_first;
  logic push;

  lap3_pkg::line_pair_t lb_rd;
  lap3_pkg::line_pair_t lb_wr;
  lap3_pkg::col_t       new_col;
  lap3_pkg::col_t       right_col;
  lap3_pkg::col_t       mid_col;
  lap3_pkg::col_t       left_col;
  lap3_pkg::cell_ctl_t  mid_ctl;
  lap3_pkg::cell_ctl_t  left_ctl;
  lap3_pkg::res_t       res_new;

  assign pix_i.ready = !skid_vld_q;
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign in_pixels   = row_ext < h_eff;
  assign step        = in_fire && !(in_pixels && (pix_i.op == lap3_pkg::OpDrain));
  assign col_first   = (in_col_q == '0);
  assign emit        = (in_row_q >= RowW'(2)) || ((in_row_q == RowW'(1)) && !col_first);
  assign last        = col_first && (row_ext >= h_eff + CmpW'(1));
  assign restart     = emit && last;
  assign push        = step && emit;
  assign row_wrap    = (col_ext + CmpW'(1)) >= w_eff;

  always_comb begin
    new_col[0] = (in_row_q >= RowW'(2)) ? lb_rd.older : '0;
    new_col[1] = (in_row_q >= RowW'(1)) ? lb_rd.newer : '0;
    new_col[2] = in_pixels ? pix_i.pixel_in : '0;
  end

  assign lb_wr.older = new_col[1];
  assign lb_wr.newer = new_col[2];

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (step) begin
      priority if (restart) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if (row_wrap) begin
        in_col_d = '0;
        in_row_d = (in_row_q < RowSat) ? in_row_q + RowW'(1) : in_row_q;
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

  lap3_line_buf #(
    .Depth (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (in_col_d),
    .wr_en_i   (step),
    .wr_addr_i (in_col_q),
    .wr_data_i (lb_wr),
    .rd_data_o (lb_rd)
  );

  // Window: mid cell holds the last column taken, left cell the one before it
  assign mid_ctl.load   = step;
  assign mid_ctl.clear  = step && restart;
  assign left_ctl.load  = step;
  assign left_ctl.clear = step && (restart || col_first);

  lap3_cell u_cell_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mid_ctl),
    .col_i  (new_col),
    .col_o  (mid_col)
  );

  lap3_cell u_cell_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (left_ctl),
    .col_i  (mid_col),
    .col_o  (left_col)
  );

  assign right_col     = col_first ? '0 : new_col;
  assign res_new.pixel = lap3_pkg::laplace(left_col, mid_col, right_col);
  assign res_new.last  = last;

  assign pop = out_vld_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      priority if (skid_vld_q) begin
        if (pop) begin
          skid_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (out_vld_q && !pop) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end else begin
        out_vld_q <= out_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end else begin
      out_q <= out_q;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.pixel_out  = out_q.pixel;
  assign res_o.frame_last = out_q.last;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a beat while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && skid_vld_q))
    else $error("result produced while both output stages are full");

  a_restart_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && restart) |=> (in_row_q == '0 && in_col_q == '0))
    else $error("frame end did not return the position to the origin");

  a_row_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= RowSat)
    else $error("row counter beyond its saturation point");

endmodule

`default_nettype wire

// ----- hdl/lap3_cell.sv -----
// One window cell: holds a three-pixel column and takes its neighbor's column on a step.
// Depends on lap3_pkg.
`default_nettype none

module lap3_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lap3_pkg::cell_ctl_t ctl_i,
  input  wire lap3_pkg::col_t      col_i,
  output      lap3_pkg::col_t      col_o
);

  lap3_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      priority if (ctl_i.clear) begin
        col_q <= '0;
      end else if (ctl_i.load) begin
        col_q <= col_i;
      end else begin
        col_q <= col_q;
      end
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

// ----- hdl/lap3_line_buf.sv -----
// Two-row line buffer: one memory word per column holds the older and newer row pixels.
// Read is registered and addressed one beat ahead; a same-address write is bypassed.
// Depends on lap3_pkg.
`default_nettype none

module lap3_line_buf #(
  parameter int Depth = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [$clog2(Depth)-1:0]     rd_addr_i,
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(Depth)-1:0]     wr_addr_i,
  input  wire lap3_pkg::line_pair_t         wr_data_i,
  output      lap3_pkg::line_pair_t         rd_data_o
);

  lap3_pkg::line_pair_t mem [Depth];
  lap3_pkg::line_pair_t rd_q;
  lap3_pkg::line_pair_t byp_data_q;
  logic                 byp_vld_q;
  logic                 byp_vld_d;

  assign byp_vld_d = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= mem[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else begin
      byp_vld_q <= byp_vld_d;
    end
  end

  assign rd_data_o = byp_vld_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

// ----- verif/tb_laplacian_3x3_convolution_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 Laplacian filter: programs the frame size over APB,
// streams pixel and drain beats and checks every result against a built-in predictor.
// Depends on lap3_pkg, the lap3 channel interfaces and laplacian_3x3_convolution_top.

module tb_laplacian_3x3_convolution_top;

  localparam int MaxW = 1024;
  localparam int MaxH = 1024;
  localparam int ColW = $clog2(MaxW);
  localparam logic [lap3_pkg::AddrW-1:0] AddrFrameWidth  = {lap3_pkg::RegFrameWidth, 2'b00};
  localparam logic [lap3_pkg::AddrW-1:0] AddrFrameHeight = {lap3_pkg::RegFrameHeight, 2'b00};
  localparam int SettleCycles  = 8;
  localparam int HoldOffCycles = 400;
  localparam int PhaseBeats    = 200;
  localparam int LimitCycles   = 2000000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [lap3_pkg::AddrW-1:0] paddr;
  logic [lap3_pkg::DataW-1:0] pwdata;
  logic [lap3_pkg::DataW-1:0] prdata;
  logic                       pready;

  lap3_in_if  pix_ch ();
  lap3_out_if res_ch ();

  laplacian_3x3_convolution_top #(
    .MAX_WIDTH (MaxW),
    .MAX_HEIGHT(MaxH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .pix_i  (pix_ch),
    .res_o  (res_ch)
  );

  // Predictor state
  logic [lap3_pkg::CfgW-1:0] cfg_width  = lap3_pkg::FrameWidthRst;
  logic [lap3_pkg::CfgW-1:0] cfg_height = lap3_pkg::FrameHeightRst;
  lap3_pkg::pix_t            line_old [MaxW];
  lap3_pkg::pix_t            line_new [MaxW];
  lap3_pkg::col_t            win [3];
  int unsigned               in_row = 0;
  int unsigned               in_col = 0;
  bit                        frame_closed = 1'b0;
  lap3_pkg::res_t            lap_expect_q [$];

  int mismatch_cnt = 0;
  int beats_used   = 0;
  int results_seen = 0;
  int frames_seen  = 0;
  int cycle_cnt    = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_cycles  = 0;

  initial forever #6 clk_i = ~clk_i;

  initial begin
    while (cycle_cnt < LimitCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
             lap_expect_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [lap3_pkg::CfgW-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return 32'(v);
  endfunction

  function automatic lap3_pkg::pix_t lap_value(lap3_pkg::col_t a, lap3_pkg::col_t b,
                                               lap3_pkg::col_t d);
    int s;
    s = a[0] + a[1] + a[2] + d[0] + d[1] + d[2] + b[0] + b[2] - 8 * b[1];
    return s[lap3_pkg::PixW-1:0];
  endfunction

  // Returns 1 when the beat is consumed, 0 when the block drops it.
  function automatic bit lap_predict_beat(logic op, lap3_pkg::pix_t pix);
    int unsigned    w;
    int unsigned    h;
    int unsigned    row;
    int unsigned    c;
    logic [ColW-1:0] ci;
    lap3_pkg::col_t fresh;
    lap3_pkg::pix_t value;
    bit             emit;
    lap3_pkg::res_t want;
    w = eff_dim(cfg_width, MaxW);
    h = eff_dim(cfg_height, MaxH);
    row = in_row;
    c = in_col;
    if (row < h && op == lap3_pkg::OpDrain) return 1'b0;
    if (c >= MaxW) c = MaxW - 1;
    ci = c[ColW-1:0];
    fresh[0] = (row >= 2) ? line_old[ci] : '0;
    fresh[1] = (row >= 1) ? line_new[ci] : '0;
    fresh[2] = (row < h) ? pix : '0;
    line_old[ci] = fresh[1];
    line_new[ci] = fresh[2];
    emit = (row >= 2) || (row == 1 && c >= 1);
    if (c == 0) begin
      value = lap_value(win[1], win[2], '0);
      win[0] = '0;
      win[1] = '0;
      win[2] = fresh;
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = fresh;
      value = lap_value(win[0], win[1], win[2]);
    end
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < MaxH + 2) in_row++;
    end else begin
      in_col++;
    end
    if (emit) begin
      want.pixel = value;
      want.last = (c == 0) && (row >= h + 1);
      lap_expect_q.push_back(want);
      if (want.last) begin
        win[0] = '0;
        win[1] = '0;
        win[2] = '0;
        in_row = 0;
        in_col = 0;
        frame_closed = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h", what, results_seen,
             got, want);
    mismatch_cnt++;
  endtask

  task automatic check_result(lap3_pkg::pix_t got_pix, logic got_last);
    lap3_pkg::res_t want;
    results_seen++;
    if (lap_expect_q.size() == 0) begin
      report_mismatch("result with none pending", {24'd0, got_pix}, 32'hx);
      return;
    end
    want = lap_expect_q.pop_front();
    if (got_pix !== want.pixel) begin
      report_mismatch("pixel_out", {24'd0, got_pix}, {24'd0, want.pixel});
    end
    if (got_last !== want.last) begin
      report_mismatch("frame_last", {31'd0, got_last}, {31'd0, want.last});
    end
    if (want.last) frames_seen++;
  endtask

  // Result sink: check each beat, then pick ready for the next cycle.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) check_result(res_ch.pixel_out, res_ch.frame_last);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_beat(logic op, lap3_pkg::pix_t pix);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.op <= op;
    pix_ch.pixel_in <= pix;
    do @(posedge clk_i); while (pix_ch.ready !== 1'b1);
    if (lap_predict_beat(op, pix)) beats_used++;
  endtask

  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    while (lap_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [lap3_pkg::AddrW-1:0] addr,
                           logic [lap3_pkg::CfgW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= lap3_pkg::DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (addr == AddrFrameWidth) cfg_width = val;
    else cfg_height = val;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [lap3_pkg::AddrW-1:0] addr,
                          output logic [lap3_pkg::DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(logic [lap3_pkg::AddrW-1:0] addr,
                           logic [lap3_pkg::CfgW-1:0] want);
    logic [lap3_pkg::DataW-1:0] got;
    apb_read(addr, got);
    if (got[lap3_pkg::CfgW-1:0] !== want) report_mismatch("register readback", got, 32'(want));
  endtask

  task automatic set_frame(logic [lap3_pkg::CfgW-1:0] w, logic [lap3_pkg::CfgW-1:0] h);
    wait_idle();
    apb_write(AddrFrameWidth, w);
    apb_write(AddrFrameHeight, h);
    check_reg(AddrFrameWidth, w);
    check_reg(AddrFrameHeight, h);
  endtask

  function automatic lap3_pkg::pix_t pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return lap3_pkg::pix_t'($urandom);
    endcase
  endfunction

  // Full frame at the current size; noisy adds dropped drains and pixels as drains.
  task automatic send_frame(bit noisy, int pause_at);
    int total;
    total = eff_dim(cfg_width, MaxW) * eff_dim(cfg_height, MaxH);
    frame_closed = 1'b0;
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) wait_idle();
      if (noisy && $urandom_range(0, 99) < 5) begin
        push_beat(lap3_pkg::OpDrain, lap3_pkg::pix_t'($urandom));
      end
      push_beat(lap3_pkg::OpPixel, pick_pixel());
    end
    while (!frame_closed) begin
      push_beat((noisy && $urandom_range(0, 99) < 15) ? lap3_pkg::OpPixel : lap3_pkg::OpDrain,
                lap3_pkg::pix_t'($urandom));
    end
    if (noisy && $urandom_range(0, 99) < 10) begin
      push_beat(lap3_pkg::OpDrain, lap3_pkg::pix_t'($urandom));
    end
  endtask

  task automatic test_register_reset();
    check_reg(AddrFrameWidth, lap3_pkg::FrameWidthRst);
    check_reg(AddrFrameHeight, lap3_pkg::FrameHeightRst);
  endtask

  task automatic test_directed_frames();
    set_frame(11'd3, 11'd3);
    frame_closed = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_beat(lap3_pkg::OpDrain, 8'hFF);
      push_beat(lap3_pkg::OpPixel, (i == 4) ? 8'hFF : 8'h00);
    end
    push_beat(lap3_pkg::OpPixel, 8'hA5);
    while (!frame_closed) push_beat(lap3_pkg::OpDrain, 8'h5A);
    frame_closed = 1'b0;
    for (int i = 0; i < 9; i++) push_beat(lap3_pkg::OpPixel, (i == 4) ? 8'h00 : 8'hFF);
    while (!frame_closed) push_beat(lap3_pkg::OpDrain, 8'h00);
    set_frame('0, '0);
    frame_closed = 1'b0;
    push_beat(lap3_pkg::OpDrain, 8'h3C);
    push_beat(lap3_pkg::OpPixel, 8'h80);
    while (!frame_closed) push_beat(lap3_pkg::OpDrain, 8'hC3);
  endtask

  task automatic test_random_frames();
    int start;
    start = beats_used;
    while (beats_used - start < PhaseBeats) begin
      if ($urandom_range(0, 1)) begin
        set_frame(($urandom_range(0, 4) == 0) ? lap3_pkg::CfgW'($urandom_range(11, 40))
                                               : lap3_pkg::CfgW'($urandom_range(0, 10)),
                  ($urandom_range(0, 4) == 0) ? lap3_pkg::CfgW'($urandom_range(9, 16))
                                               : lap3_pkg::CfgW'($urandom_range(0, 8)));
      end
      send_frame(1'b1, -1);
    end
  endtask

  task automatic test_output_stall();
    set_frame(11'd6, 11'd5);
    hold_cycles = HoldOffCycles;
    send_frame(1'b0, -1);
  endtask

  task automatic test_sender_pause();
    set_frame(11'd5, 11'd4);
    send_frame(1'b0, 11);
  endtask

  task automatic test_size_extremes();
    set_frame(11'd1, 11'd2047);
    send_frame(1'b0, -1);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.op = lap3_pkg::OpPixel;
    pix_ch.pixel_in = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    tx_idle_pct = 21;
    rx_idle_pct = 61;
    test_register_reset();
    test_directed_frames();
    test_random_frames();

    tx_idle_pct = 61;
    rx_idle_pct = 21;
    test_random_frames();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_sender_pause();
    test_random_frames();
    test_size_extremes();

    wait_idle();
    $display("checked %0d results in %0d frames from %0d consumed beats", results_seen,
             frames_seen, beats_used);
    $display("frames from 1x1 up to 40 wide and a clamped 1024-row column, with gaps and stalls");
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
